[sv/rssl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssl_pkg
// Shared constants and types of the row sub-pixel shift block.
// ----------------------------------------------------------------------------
package rssl_pkg;

  localparam int MAX_ROW_WIDTH   = 2048;
  localparam int FRACTION_BITS   = 16;

  localparam int PIX_W           = 32;
  localparam int RW_REG_W        = 12;
  localparam int RPP_W           = 13;
  localparam int ROWCNT_W        = RPP_W;
  localparam int ADDR_W          = 4;
  localparam int ROW_WIDTH_RESET = 2048;

  localparam int COL_W   = $clog2(MAX_ROW_WIDTH);
  localparam int WID_W   = $clog2(MAX_ROW_WIDTH + 1);
  localparam int INT_W   = PIX_W - FRACTION_BITS;
  localparam int POS_W   = ((INT_W > WID_W) ? INT_W : WID_W) + 2;
  localparam int WGT_W   = FRACTION_BITS + 1;
  localparam int RAM_AW  = COL_W + 1;
  localparam int RAM_D   = 2 * (1 << COL_W);
  localparam int PROD_W  = PIX_W + WGT_W + 1;
  localparam int SUM_W   = PROD_W + 1;

  localparam logic [1:0] REG_SLOPE     = 2'd0;
  localparam logic [1:0] REG_INTERCEPT = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH = 2'd2;
  localparam logic [1:0] REG_ROWS      = 2'd3;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_in;
    logic                    flush;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_out;
    logic                    out_valid;
    logic                    row_end;
    logic                    projection_end;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] slope;
    logic [WID_W-1:0] width;
    logic [RPP_W-1:0] rpp;
    logic             shift_load;
    logic [PIX_W-1:0] shift_value;
  } cfg_t;

  typedef struct packed {
    logic                     have;
    logic                     row_end;
    logic                     proj_end;
    logic                     in_win;
    logic                     ok_lo;
    logic                     ok_hi;
    logic [WGT_W-1:0]         w_lo;
    logic [FRACTION_BITS-1:0] w_hi;
  } tap_t;

endpackage

[sv/rssl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rssl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/rssl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssl_ctrl
// Row/column counters, ping-pong bank, shift accumulation and tap addressing.
// ----------------------------------------------------------------------------
module rssl_ctrl
  import rssl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  in_item_t          item,
  output tap_t              tap,
  output logic              we,
  output logic [RAM_AW-1:0] waddr,
  output logic [PIX_W-1:0]  wdata,
  output logic [RAM_AW-1:0] raddr_lo,
  output logic [RAM_AW-1:0] raddr_hi
);

  logic                bank;
  logic [COL_W-1:0]    col;
  logic [ROWCNT_W-1:0] row_count;
  logic [PIX_W-1:0]    cur_shift;
  logic [PIX_W-1:0]    held_shift;
  logic                have_row;
  logic                held_last;

  logic                last_col;
  logic                last_row;
  logic signed [INT_W-1:0] lo;
  logic signed [POS_W-1:0] pos_i, pos_lo, pos_w, idx_lo, idx_hi, pos_max;
  logic                zero_shift;

  assign last_col = (WID_W'(col) + WID_W'(1)) >= cfg.width;
  assign last_row = (RPP_W'(row_count) + RPP_W'(1)) >= cfg.rpp;

  assign lo         = held_shift[PIX_W-1:FRACTION_BITS];
  assign zero_shift = held_shift == '0;
  assign pos_i      = $signed(POS_W'(col));
  assign pos_lo     = POS_W'(lo);
  assign pos_w      = $signed(POS_W'(cfg.width));
  assign pos_max    = POS_W'(MAX_ROW_WIDTH);
  assign idx_lo     = pos_i + pos_lo;
  assign idx_hi     = idx_lo + POS_W'(1);

  always_comb begin
    tap.have     = have_row;
    tap.row_end  = have_row && last_col;
    tap.proj_end = have_row && last_col && held_last;
    tap.w_hi     = held_shift[FRACTION_BITS-1:0];
    tap.w_lo     = (WGT_W'(1) << FRACTION_BITS) - WGT_W'(held_shift[FRACTION_BITS-1:0]);
    tap.ok_lo    = (idx_lo >= POS_W'(0)) && (idx_lo < pos_max);
    tap.ok_hi    = (idx_hi >= POS_W'(0)) && (idx_hi < pos_max);
    priority if (zero_shift) begin
      tap.in_win = pos_i < pos_w;
    end else if (!held_shift[PIX_W-1]) begin
      tap.in_win = pos_i < (pos_w - pos_lo - POS_W'(1));
    end else begin
      tap.in_win = (pos_i >= -pos_lo) && (pos_i < pos_w);
    end
  end

  assign raddr_lo = {~bank, idx_lo[COL_W-1:0]};
  assign raddr_hi = {~bank, idx_hi[COL_W-1:0]};
  assign we       = accept && !item.flush;
  assign waddr    = {bank, col};
  assign wdata    = item.pixel_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank       <= 1'b0;
      col        <= '0;
      row_count  <= '0;
      cur_shift  <= '0;
      held_shift <= '0;
      have_row   <= 1'b0;
      held_last  <= 1'b0;
    end else if (cfg.shift_load) begin
      cur_shift <= cfg.shift_value;
    end else if (accept) begin
      if (item.flush) begin
        if (have_row) begin
          if (last_col) begin
            have_row <= 1'b0;
            col      <= '0;
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end else if (last_col) begin
        held_shift <= cur_shift;
        held_last  <= last_row;
        bank       <= ~bank;
        have_row   <= 1'b1;
        col        <= '0;
        if (last_row) begin
          row_count <= '0;
          cur_shift <= cur_shift + cfg.slope;
        end else begin
          row_count <= row_count + ROWCNT_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

[sv/rssl_interp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssl_interp
// Interpolation pipeline: tap capture, two weight multiplies, sum and output.
// ----------------------------------------------------------------------------
module rssl_interp
  import rssl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  tap_t             tap,
  input  logic [PIX_W-1:0] rd_lo,
  input  logic [PIX_W-1:0] rd_hi,
  input  logic             res_stall,
  output logic             take,
  output logic             res_valid,
  output out_item_t        res_item
);

  logic v1, v2, v3;
  logic en1, en2, en3;
  tap_t tap1;

  logic                     have2, win2, row_end2, proj_end2;
  logic signed [PROD_W-1:0] p_lo, p_hi;
  logic signed [SUM_W-1:0]  sum;
  logic [PIX_W-1:0]         a_lo, a_hi;

  assign en3  = !v3 || !res_stall;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign take = en1;

  // upper tap only counts when its weight is nonzero
  assign a_lo = tap1.ok_lo ? rd_lo : '0;
  assign a_hi = (tap1.ok_hi && (tap1.w_hi != '0)) ? rd_hi : '0;
  assign sum  = SUM_W'(p_lo) + SUM_W'(p_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tap1 <= tap;
    end
    if (en2) begin
      p_lo      <= $signed(a_lo) * $signed({1'b0, tap1.w_lo});
      p_hi      <= $signed(a_hi) * $signed({2'b00, tap1.w_hi});
      have2     <= tap1.have;
      win2      <= tap1.in_win;
      row_end2  <= tap1.row_end;
      proj_end2 <= tap1.proj_end;
    end
    if (en3) begin
      res_item.pixel_out      <= (have2 && win2) ? sum[FRACTION_BITS +: PIX_W] : '0;
      res_item.out_valid      <= have2;
      res_item.row_end        <= row_end2;
      res_item.projection_end <= proj_end2;
    end
  end

  assign res_valid = v3;

endmodule

[sv/row_subpixel_shift_linear.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_subpixel_shift_linear
// Fractional shift of each row by linear interpolation over ping-pong rows.
// ----------------------------------------------------------------------------
// One item is taken per clock unless the pipeline is full behind a stalled
// output; each item gives one result. The held row is read at two columns
// per item, so the row store is kept as two identical copies, each with one
// write and one read port; a pixel written in one cycle is visible to a read
// in the next. Results move through a three-stage pipeline that keeps taking
// items until all three stages are full behind a stalled output.
module row_subpixel_shift_linear
  import rssl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              res_valid,
  input  logic              res_stall,
  output out_item_t         res_item
);

  localparam int CMP_W = (WID_W > RW_REG_W) ? WID_W : RW_REG_W;

  logic [PIX_W-1:0]    shift_slope;
  logic [PIX_W-1:0]    shift_intercept;
  logic [RW_REG_W-1:0] row_width;
  logic [RPP_W-1:0]    rows_per_projection;

  logic              wr;
  logic [1:0]        reg_idx;
  logic [CMP_W-1:0]  rw_x;
  cfg_t              cfg;
  tap_t              tap;
  logic              take, accept, we;
  logic [RAM_AW-1:0] waddr, raddr_lo, raddr_hi;
  logic [PIX_W-1:0]  wdata, rd_lo, rd_hi;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_slope         <= '0;
      shift_intercept     <= '0;
      row_width           <= RW_REG_W'(ROW_WIDTH_RESET);
      rows_per_projection <= RPP_W'(1);
    end else if (wr) begin
      unique case (reg_idx)
        REG_SLOPE:     shift_slope         <= pwdata;
        REG_INTERCEPT: shift_intercept     <= pwdata;
        REG_ROW_WIDTH: row_width           <= pwdata[RW_REG_W-1:0];
        REG_ROWS:      rows_per_projection <= pwdata[RPP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SLOPE:     prdata = shift_slope;
      REG_INTERCEPT: prdata = shift_intercept;
      REG_ROW_WIDTH: prdata = 32'(row_width);
      REG_ROWS:      prdata = 32'(rows_per_projection);
    endcase
  end

  assign rw_x = CMP_W'(row_width);

  always_comb begin
    cfg.slope       = shift_slope;
    cfg.shift_load  = wr && (reg_idx == REG_INTERCEPT);
    cfg.shift_value = pwdata;
    cfg.rpp         = (rows_per_projection == '0) ? RPP_W'(1) : rows_per_projection;
    priority if (rw_x == '0) begin
      cfg.width = WID_W'(1);
    end else if (rw_x > CMP_W'(MAX_ROW_WIDTH)) begin
      cfg.width = WID_W'(MAX_ROW_WIDTH);
    end else begin
      cfg.width = rw_x[WID_W-1:0];
    end
  end

  assign in_stall = !take;
  assign accept   = in_valid && take;

  rssl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .item     (in_item),
    .tap      (tap),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr_lo (raddr_lo),
    .raddr_hi (raddr_hi)
  );

  rssl_ram #(.WIDTH(PIX_W), .DEPTH(RAM_D)) u_ram_lo (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (take),
    .raddr (raddr_lo),
    .rdata (rd_lo)
  );

  rssl_ram #(.WIDTH(PIX_W), .DEPTH(RAM_D)) u_ram_hi (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (take),
    .raddr (raddr_hi),
    .rdata (rd_hi)
  );

  rssl_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .tap       (tap),
    .rd_lo     (rd_lo),
    .rd_hi     (rd_hi),
    .res_stall (res_stall),
    .take      (take),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

endmodule

[sv/rssl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssl_checker
// Port-level checks on the result channel of the row shift block.
// ----------------------------------------------------------------------------
module rssl_checker
  import rssl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input out_item_t res_item
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_no_row_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_item.out_valid) |->
      (res_item.pixel_out == '0 && !res_item.row_end && !res_item.projection_end))
    else $error("result without held row carries data");

  a_proj_row: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.projection_end) |-> res_item.row_end)
    else $error("projection end without row end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_item)))
    else $error("stalled result changed");

endmodule

bind row_subpixel_shift_linear rssl_checker u_rssl_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the row sub-pixel shift block.
// ----------------------------------------------------------------------------
// Pixels and flushes are queued per phase and driven over the valid/stall
// port. Expected pixels are worked out as each item is queued, from a local
// model of the ping-pong row store, the row and projection counters and the
// accumulated shift. Register writes go over the APB port only while the
// block is empty. A directed opening covers the corner cases. A short phase
// at an over-range width and randomized phases, most with random stalls on
// both sides, follow.
// ----------------------------------------------------------------------------
module testbench;
  import rssl_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              res_valid;
  logic              res_stall = 1'b0;
  out_item_t         res_item;

  row_subpixel_shift_linear DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
  );

  always #4 clk = ~clk;

  // local copy of registers and state
  logic [31:0]         slope_r;
  logic [31:0]         intercept_r;
  logic [RW_REG_W-1:0] width_r;
  logic [RPP_W-1:0]    rows_r;
  logic signed [31:0]  row_mem [0:2*MAX_ROW_WIDTH-1];
  bit                  row_written [0:2*MAX_ROW_WIDTH-1];
  bit                  wr_bank;
  int                  col_idx;
  int                  row_idx;
  logic [31:0]         proj_shift;
  logic [31:0]         held_shift;
  bit                  row_held;
  bit                  held_proj_end;

  in_item_t  pending_px [$];
  out_item_t expected_px [$];

  int idle_mode;
  bit hold_arm;
  bit hold_done;
  int hold_left;
  int errors;
  int n_items;
  int n_flush;
  int n_checked;
  int n_writes;
  int widest;

  function automatic int active_width();
    if (width_r == 0) return 1;
    if (width_r > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
    return int'(width_r);
  endfunction

  function automatic longint held_px(longint c);
    int base;
    base = wr_bank ? 0 : MAX_ROW_WIDTH;
    if (c < 0 || c >= MAX_ROW_WIDTH) return 0;
    return longint'(row_mem[base + int'(c)]);
  endfunction

  function automatic logic [31:0] interp_px(int c, int w);
    longint s, lo, hi, w_hi, w_lo, win_lo, win_hi, acc;
    s = longint'($signed(held_shift));
    if (s == 0) return (c < w) ? held_px(c) : 0;
    lo = s >>> FRACTION_BITS;
    hi = lo + 1;
    w_hi = s - (lo <<< FRACTION_BITS);
    w_lo = (longint'(1) <<< FRACTION_BITS) - w_hi;
    if (s >= 0) begin
      win_lo = 0;
      win_hi = w - hi;
    end else begin
      win_lo = -lo;
      win_hi = w;
    end
    if (c < win_lo || c >= win_hi) return 0;
    acc = held_px(c + lo) * w_lo + held_px(c + hi) * w_hi;
    return acc >>> FRACTION_BITS;
  endfunction

  function automatic bit held_clean(int w);
    int base;
    base = wr_bank ? 0 : MAX_ROW_WIDTH;
    for (int c = 0; c < w; c++)
      if (!row_written[base + c]) return 1'b0;
    return 1'b1;
  endfunction

  // advance the local state by one item and queue the pixel it yields
  function automatic void shift_row_step(in_item_t it);
    out_item_t r;
    int w;
    int rpp;
    bit last;
    w = active_width();
    rpp = (rows_r == 0) ? 1 : int'(rows_r);
    last = (col_idx + 1 >= w);
    r = '0;
    if (row_held) begin
      r.pixel_out = interp_px(col_idx, w);
      r.out_valid = 1'b1;
      r.row_end = last;
      r.projection_end = last && held_proj_end;
    end
    expected_px.push_back(r);
    if (it.flush) begin
      if (row_held) begin
        if (last) begin
          row_held = 1'b0;
          col_idx = 0;
        end else begin
          col_idx++;
        end
      end
      return;
    end
    row_mem[(wr_bank ? MAX_ROW_WIDTH : 0) + col_idx] = it.pixel_in;
    row_written[(wr_bank ? MAX_ROW_WIDTH : 0) + col_idx] = 1'b1;
    if (last) begin
      held_shift = proj_shift;
      held_proj_end = (row_idx + 1 >= rpp);
      wr_bank = ~wr_bank;
      row_held = 1'b1;
      col_idx = 0;
      if (held_proj_end) begin
        row_idx = 0;
        proj_shift = proj_shift + slope_r;
      end else begin
        row_idx++;
      end
    end else begin
      col_idx++;
    end
  endfunction

  // a flush that would leave a never-written column in the next held row
  // is sent as a pixel instead
  function automatic void add_item(bit fl, logic [31:0] px);
    in_item_t it;
    int w;
    w = active_width();
    if (fl && row_held && col_idx + 1 < w &&
        !row_written[(wr_bank ? MAX_ROW_WIDTH : 0) + col_idx])
      fl = 1'b0;
    it.pixel_in = px;
    it.flush = fl;
    shift_row_step(it);
    pending_px.push_back(it);
    n_items++;
    if (fl) n_flush++;
    if (w > widest) widest = w;
  endfunction

  function automatic logic [31:0] rand_px();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic bit idle_draw(int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic wait_drained();
    while (pending_px.size() != 0 || expected_px.size() != 0) @(posedge clk);
  endtask

  task automatic drain_held();
    while (row_held) add_item(1'b1, rand_px());
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    int new_w;
    wait_drained();
    if (idx == REG_ROW_WIDTH) begin
      new_w = (val[11:0] == 0) ? 1 :
              (val[11:0] > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : int'(val[11:0]);
      if (row_held && !held_clean(new_w)) begin
        drain_held();
        wait_drained();
      end
    end
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SLOPE: slope_r = val;
      REG_INTERCEPT: begin
        intercept_r = val;
        proj_shift = val;
      end
      REG_ROW_WIDTH: width_r = val[RW_REG_W-1:0];
      REG_ROWS: rows_r = val[RPP_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_px.size() != 0 &&
          !idle_draw(idle_mode == 0 ? 6 : idle_mode == 1 ? 69 : 0)) begin
        in_valid <= 1'b1;
        in_item <= pending_px.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (hold_arm && !hold_done) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= idle_draw(idle_mode == 0 ? 69 : idle_mode == 1 ? 6 : 0);
      end
    end
  end

  // result checker
  out_item_t exp_r;
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (expected_px.size() == 0) begin
        $error("result with none expected: %h", res_item);
        errors++;
      end else begin
        exp_r = expected_px.pop_front();
        n_checked++;
        if (res_item.pixel_out !== exp_r.pixel_out) begin
          $error("pixel_out: expected %h, got %h", exp_r.pixel_out, res_item.pixel_out);
          errors++;
        end
        if (res_item.out_valid !== exp_r.out_valid) begin
          $error("out_valid: expected %b, got %b", exp_r.out_valid, res_item.out_valid);
          errors++;
        end
        if (res_item.row_end !== exp_r.row_end) begin
          $error("row_end: expected %b, got %b", exp_r.row_end, res_item.row_end);
          errors++;
        end
        if (res_item.projection_end !== exp_r.projection_end) begin
          $error("projection_end: expected %b, got %b",
                 exp_r.projection_end, res_item.projection_end);
          errors++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int w;
    int k;
    logic [31:0] icpt;
    slope_r = '0;
    intercept_r = '0;
    width_r = RW_REG_W'(ROW_WIDTH_RESET);
    rows_r = RPP_W'(1);
    for (k = 0; k < 2 * MAX_ROW_WIDTH; k++) begin
      row_mem[k] = '0;
      row_written[k] = 1'b0;
    end
    wr_bank = 1'b0;
    col_idx = 0;
    row_idx = 0;
    proj_shift = '0;
    held_shift = '0;
    row_held = 1'b0;
    held_proj_end = 1'b0;
    idle_mode = 0;
    hold_arm = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    errors = 0;
    n_items = 0;
    n_flush = 0;
    n_checked = 0;
    n_writes = 0;
    widest = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: flushes with no held row around a first pixel
    add_item(1'b1, rand_px());
    add_item(1'b0, 32'h7fff_ffff);
    add_item(1'b1, rand_px());

    // narrow the row mid-stream, zero shift, zero rows per projection
    write_reg(REG_ROW_WIDTH, 32'd3);
    write_reg(REG_ROWS, 32'd0);
    write_reg(REG_SLOPE, 32'h7fff_ffff);
    write_reg(REG_INTERCEPT, 32'h0000_0000);
    add_item(1'b0, 32'h8000_0000);
    add_item(1'b0, 32'hffff_ffff);
    add_item(1'b0, 32'h0000_0000);
    add_item(1'b0, 32'h0000_0001);
    add_item(1'b0, 32'h0000_0002);
    add_item(1'b1, rand_px());
    add_item(1'b1, rand_px());
    add_item(1'b1, rand_px());

    // half-pixel left shift, two rows per projection, shift wraps
    write_reg(REG_SLOPE, 32'h8000_0000);
    write_reg(REG_INTERCEPT, 32'hffff_8000);
    write_reg(REG_ROWS, 32'd2);
    add_item(1'b0, 32'h7fff_ffff);
    add_item(1'b0, 32'h8000_0000);
    add_item(1'b0, 32'hffff_ffff);
    add_item(1'b0, 32'h0000_0001);
    add_item(1'b0, 32'hffff_ffff);
    add_item(1'b0, 32'h0001_0000);
    add_item(1'b0, rand_px());
    add_item(1'b0, rand_px());
    add_item(1'b0, rand_px());
    add_item(1'b1, rand_px());
    add_item(1'b1, rand_px());
    add_item(1'b1, rand_px());

    // zero width acts as one, most negative intercept
    write_reg(REG_ROW_WIDTH, 32'd0);
    write_reg(REG_INTERCEPT, 32'h8000_0000);
    write_reg(REG_SLOPE, 32'h0000_8000);
    add_item(1'b0, rand_px());
    add_item(1'b0, rand_px());

    // width above the maximum, row left partly written, then narrowed
    write_reg(REG_ROW_WIDTH, 32'd4095);
    write_reg(REG_ROWS, 32'd1);
    write_reg(REG_INTERCEPT, 32'h0002_c000);
    write_reg(REG_SLOPE, 32'hfffa_8000);
    for (k = 0; k < 24; k++)
      add_item(1'b0, rand_px());

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      idle_mode = (ph < 3) ? 0 : (ph < 6) ? 1 : 2;
      case ($urandom_range(9))
        0: write_reg(REG_SLOPE, 32'h0000_0000);
        1: write_reg(REG_SLOPE, $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff);
        default: write_reg(REG_SLOPE, int'($urandom_range(0, 4 * 65536)) - 2 * 65536);
      endcase
      case ($urandom_range(9))
        0: write_reg(REG_ROWS, 32'd0);
        1: write_reg(REG_ROWS, 32'd8191);
        2: write_reg(REG_ROWS, 32'd4096);
        default: write_reg(REG_ROWS, $urandom_range(1, 4));
      endcase
      case ($urandom_range(9))
        0: w = 0;
        1: w = 1;
        2: w = $urandom_range(33, 64);
        default: w = $urandom_range(2, 12);
      endcase
      write_reg(REG_ROW_WIDTH, w);
      if (w == 0) w = 1;
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(7))
          0: icpt = 32'h0;
          1: icpt = $urandom;
          default: icpt = int'($urandom_range(0, (2 * w + 2) * 65536)) - (w + 1) * 65536;
        endcase
        if ($urandom_range(4) == 0) icpt[15:0] = '0;
        write_reg(REG_INTERCEPT, icpt);
      end
      for (k = 0; k < 150; k++) begin
        if (row_held && idle_draw(3))
          drain_held();
        else
          add_item(idle_draw(8), rand_px());
      end
      if (ph == 6) hold_arm = 1'b1;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d items (%0d flushes) over %0d register writes, rows up to %0d wide",
             n_items, n_flush, n_writes, widest);
    $display("checked %0d shifted pixels, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/rssl_pkg.sv
sv/rssl_ram.sv
sv/rssl_ctrl.sv
sv/rssl_interp.sv
sv/row_subpixel_shift_linear.sv
sv/rssl_checker.sv
sim/testbench.sv
